/* design/sitp_pkg.sv */
// sitp_pkg: shared types and constants for the signed integer text parser
// parse phase encoding, radix select codes, controller/datapath command and status words
// no dependencies
package sitp_pkg;

   localparam int VALUE_W  = 64;
   localparam int RADIX_W  = 6;
   localparam int PROD_W   = VALUE_W + RADIX_W;
   localparam int CHAR_W   = 8;
   localparam int OUT_OFF_W = 16;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;

   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] UPPER_BIAS = 8'd55;   // 'A' - 10
   localparam logic [CHAR_W-1:0] LOWER_BIAS = 8'd87;   // 'a' - 10

   localparam logic [VALUE_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_SPACE  = 5'b00010,
      PH_SIGNED = 5'b00100,
      PH_ZERO   = 5'b01000,
      PH_DIGITS = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      RS_KEEP    = 2'd0,   // radix register unchanged, or loaded with the configured radix at a string start
      RS_ACTIVE  = 2'd1,   // auto maps to decimal
      RS_HEX     = 2'd2,
      RS_RESOLVE = 2'd3    // after a leading zero: auto gives octal, else hex
   } radix_sel_type;

   typedef struct packed {
      logic          start;
      logic          step_index;
      logic          set_neg;
      logic          set_digits;
      logic          digit_update;
      logic          emit;
      radix_sel_type radix_sel;
   } cmd_type;

   typedef struct packed {
      logic is_space;
      logic is_minus;
      logic is_plus;
      logic is_zero;
      logic is_x;
      logic auto_or_hex;
      logic digit_ok;
   } status_type;

endpackage

/* design/sitp_ctrl.sv */
// sitp_ctrl: parse phase state machine and handshake control
// drives datapath commands from character status; uses sitp_pkg
module sitp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_string_start,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sitp_pkg::status_type st,
   output sitp_pkg::cmd_type    cmd
);

   sitp_pkg::phase_type phase_ff, phase_in, cur;
   logic settle_ff, settle_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, live, take, begin_num;

   // settle_ff holds req_ready low after each accepted word so the product register can catch up
   assign req_ready = !settle_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.start        = 1'b0;
      cmd.step_index   = 1'b0;
      cmd.set_neg      = 1'b0;
      cmd.set_digits   = 1'b0;
      cmd.digit_update = 1'b0;
      cmd.emit         = 1'b0;
      cmd.radix_sel    = sitp_pkg::RS_KEEP;
      phase_in  = phase_ff;
      cur       = phase_ff;
      live      = 1'b0;
      take      = 1'b0;
      begin_num = 1'b0;
      if (accept) begin
         if (req_string_start) begin
            cmd.start = 1'b1;
            cur       = sitp_pkg::PH_SPACE;
            live      = 1'b1;
         end else if (phase_ff != sitp_pkg::PH_IDLE) begin
            cmd.step_index = 1'b1;
            live           = 1'b1;
         end
      end
      if (live) begin
         unique case (cur)
            sitp_pkg::PH_SPACE: begin
               phase_in = sitp_pkg::PH_SPACE;
               if (st.is_space) begin
                  phase_in = sitp_pkg::PH_SPACE;
               end else if (st.is_minus) begin
                  cmd.set_neg = 1'b1;
                  phase_in    = sitp_pkg::PH_SIGNED;
               end else if (st.is_plus) begin
                  phase_in = sitp_pkg::PH_SIGNED;
               end else begin
                  begin_num = 1'b1;
               end
            end
            sitp_pkg::PH_SIGNED: begin
               begin_num = 1'b1;
            end
            sitp_pkg::PH_ZERO: begin
               phase_in = sitp_pkg::PH_DIGITS;
               if (st.is_x) begin
                  cmd.radix_sel = sitp_pkg::RS_HEX;
               end else begin
                  cmd.radix_sel  = sitp_pkg::RS_RESOLVE;
                  cmd.set_digits = 1'b1;
                  take           = 1'b1;
               end
            end
            sitp_pkg::PH_DIGITS: begin
               take = 1'b1;
            end
            default: begin
               phase_in = sitp_pkg::PH_IDLE;
            end
         endcase
         if (begin_num) begin
            if (st.auto_or_hex && st.is_zero) begin
               phase_in = sitp_pkg::PH_ZERO;
            end else begin
               cmd.radix_sel = sitp_pkg::RS_ACTIVE;
               phase_in      = sitp_pkg::PH_DIGITS;
               take          = 1'b1;
            end
         end
         if (take) begin
            if (st.digit_ok) begin
               cmd.digit_update = 1'b1;
            end else begin
               cmd.emit = 1'b1;
               phase_in = sitp_pkg::PH_IDLE;
            end
         end
      end
   end

   assign settle_in    = accept;
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sitp_pkg::PH_IDLE;
         settle_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/sitp_datapath.sv */
// sitp_datapath: character decode, accumulator with multiply-add and saturation, offset counter
// radix register, product register and result registers; uses sitp_pkg
module sitp_datapath #(
   parameter int OFFSET_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sitp_pkg::RADIX_W-1:0]        csr_write_data,
   input  logic [sitp_pkg::CHAR_W-1:0]         req_text_char,
   input  sitp_pkg::cmd_type                   cmd,
   output sitp_pkg::status_type                st,
   output logic signed [sitp_pkg::VALUE_W-1:0] rsp_parsed_value,
   output logic                                rsp_range_error,
   output logic [sitp_pkg::OUT_OFF_W-1:0]      rsp_end_offset
);

   localparam logic [OFFSET_WIDTH-1:0] IDX_MAX = {OFFSET_WIDTH{1'b1}};

   logic [sitp_pkg::RADIX_W-1:0] csr_radix_ff, csr_radix_in;
   logic [sitp_pkg::RADIX_W-1:0] radix_ff, radix_in, base;
   logic [sitp_pkg::VALUE_W-1:0] acc_ff, acc_in, acc_base;
   logic [sitp_pkg::PROD_W-1:0]  prod_ff, prod_in, prod_base, sum;
   logic                         neg_ff, neg_in;
   logic                         ovf_ff, ovf_in, ovf_base;
   logic                         digits_ff, digits_in;
   logic [OFFSET_WIDTH-1:0]      idx_ff, idx_in;
   logic [OFFSET_WIDTH+sitp_pkg::OUT_OFF_W-1:0] idx_ext;
   logic [sitp_pkg::VALUE_W-1:0] limit, value_in, value_ff;
   logic                         range_ff;
   logic [sitp_pkg::OUT_OFF_W-1:0] offset_in, offset_ff;
   logic [sitp_pkg::CHAR_W-1:0]  c, dig8;
   logic [sitp_pkg::RADIX_W-1:0] dig;
   logic                         alnum;

   assign c = req_text_char;

   always_comb begin
      alnum = 1'b1;
      dig8  = '0;
      if (c >= sitp_pkg::CH_ZERO && c <= sitp_pkg::CH_NINE) begin
         dig8 = c - sitp_pkg::CH_ZERO;
      end else if (c >= sitp_pkg::CH_UPPER_A && c <= sitp_pkg::CH_UPPER_Z) begin
         dig8 = c - sitp_pkg::UPPER_BIAS;
      end else if (c >= sitp_pkg::CH_LOWER_A && c <= sitp_pkg::CH_LOWER_Z) begin
         dig8 = c - sitp_pkg::LOWER_BIAS;
      end else begin
         alnum = 1'b0;
      end
   end
   assign dig = dig8[sitp_pkg::RADIX_W-1:0];

   // a new string starts from the configured radix and a cleared accumulator
   assign base = cmd.start ? csr_radix_ff : radix_ff;

   always_comb begin
      unique case (cmd.radix_sel)
         sitp_pkg::RS_KEEP:    radix_in = base;
         sitp_pkg::RS_ACTIVE:  radix_in = (base == sitp_pkg::RADIX_AUTO) ? sitp_pkg::RADIX_DEC
                                                                         : base;
         sitp_pkg::RS_HEX:     radix_in = sitp_pkg::RADIX_HEX;
         sitp_pkg::RS_RESOLVE: radix_in = (base == sitp_pkg::RADIX_AUTO) ? sitp_pkg::RADIX_OCT
                                                                         : sitp_pkg::RADIX_HEX;
         default:              radix_in = base;
      endcase
   end

   assign st.is_space    = (c == sitp_pkg::CH_SPACE) ||
                           (c >= sitp_pkg::CH_TAB && c <= sitp_pkg::CH_CR);
   assign st.is_minus    = (c == sitp_pkg::CH_MINUS);
   assign st.is_plus     = (c == sitp_pkg::CH_PLUS);
   assign st.is_zero     = (c == sitp_pkg::CH_ZERO);
   assign st.is_x        = (c == sitp_pkg::CH_LOWER_X) || (c == sitp_pkg::CH_UPPER_X);
   assign st.auto_or_hex = (base == sitp_pkg::RADIX_AUTO) || (base == sitp_pkg::RADIX_HEX);
   assign st.digit_ok    = alnum && (dig < radix_in);

   assign neg_in    = (cmd.start ? 1'b0 : neg_ff) | cmd.set_neg;
   assign ovf_base  = cmd.start ? 1'b0 : ovf_ff;
   assign acc_base  = cmd.start ? '0 : acc_ff;
   assign prod_base = cmd.start ? '0 : prod_ff;
   assign digits_in = (cmd.start ? 1'b0 : digits_ff) | cmd.set_digits | cmd.digit_update;
   assign limit     = neg_in ? sitp_pkg::VALUE_MIN : sitp_pkg::VALUE_MAX;

   // acc*radix + digit beyond the limit is the same test as the cutoff pair
   assign sum = prod_base + sitp_pkg::PROD_W'(dig);

   always_comb begin
      acc_in = acc_base;
      ovf_in = ovf_base;
      if (cmd.digit_update) begin
         if (ovf_base || (sum > sitp_pkg::PROD_W'(limit))) begin
            ovf_in = 1'b1;
         end else begin
            acc_in = sum[sitp_pkg::VALUE_W-1:0];
         end
      end
   end

   assign prod_in = sitp_pkg::PROD_W'(acc_ff) * sitp_pkg::PROD_W'(radix_ff);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.start) begin
         idx_in = '0;
      end else if (cmd.step_index && idx_ff != IDX_MAX) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   assign idx_ext   = {{sitp_pkg::OUT_OFF_W{1'b0}}, idx_in};
   assign offset_in = digits_in ? idx_ext[sitp_pkg::OUT_OFF_W-1:0] : '0;
   assign value_in  = ovf_in ? limit : (neg_in ? (~acc_in + 1'b1) : acc_in);

   assign csr_radix_in = csr_write_enable ? csr_write_data : csr_radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_radix_ff <= sitp_pkg::RADIX_RESET;
         radix_ff     <= '0;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         digits_ff    <= 1'b0;
         idx_ff       <= '0;
      end else begin
         csr_radix_ff <= csr_radix_in;
         radix_ff     <= radix_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         ovf_ff       <= ovf_in;
         digits_ff    <= digits_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.emit) begin
         value_ff  <= value_in;
         range_ff  <= ovf_in;
         offset_ff <= offset_in;
      end
   end

   assign rsp_parsed_value = value_ff;
   assign rsp_range_error  = range_ff;
   assign rsp_end_offset   = offset_ff;

endmodule

/* design/signed_integer_text_parser.sv */
// signed_integer_text_parser: streaming text to signed 64-bit integer converter
// top level joining sitp_ctrl and sitp_datapath; uses sitp_pkg
//
// Usage: one character per req_ word (req_text_char, req_string_start marks the first
// character of a string). Leading whitespace, an optional sign and, for radix 0 or 16,
// an optional 0x/0X prefix are consumed; digits up to the radix accumulate. The first
// character that is not a digit ends the string and produces one rsp_ word with the
// saturated value, the range error flag and the end offset. Characters outside a string
// are dropped; a new string_start abandons an unfinished string without a result.
// csr_write_data sets the radix (0 = auto) and is sampled at each string start.
// req_ready drops after each accepted word, so no new character is taken until the product
// register that holds accumulator times radix has been refreshed from the updated accumulator.
// The result is registered and shows on rsp_valid in the cycle after the
// terminating character is accepted.
// Reset: synchronous; the radix register returns to 10, the parser goes idle and any
// pending result is dropped. While a result waits on a low rsp_ready, req_ready stays
// low so no second result can be produced; the held result is not disturbed.
module signed_integer_text_parser #(
   parameter int OFFSET_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sitp_pkg::RADIX_W-1:0]        csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sitp_pkg::CHAR_W-1:0]         req_text_char,
   input  logic                                req_string_start,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [sitp_pkg::VALUE_W-1:0] rsp_parsed_value,
   output logic                                rsp_range_error,
   output logic [sitp_pkg::OUT_OFF_W-1:0]      rsp_end_offset
);

   sitp_pkg::cmd_type    cmd;
   sitp_pkg::status_type st;

   sitp_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_string_start (req_string_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .st               (st),
      .cmd              (cmd)
   );

   sitp_datapath #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_text_char    (req_text_char),
      .cmd              (cmd),
      .st               (st),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_range_error  (rsp_range_error),
      .rsp_end_offset   (rsp_end_offset)
   );

   // a saturated result is always one of the two extremes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |->
         (rsp_parsed_value == sitp_pkg::VALUE_MIN) || (rsp_parsed_value == sitp_pkg::VALUE_MAX))
      else $error("saturated result is not an extreme value");

   // product register refreshes after every accepted word before another word is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted before product register refreshed");

   // no result leaves the block right after reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result blocks the input side
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while a result is stalled");

endmodule

/* dv/text_parser_checker.sv */
// text_parser_checker: follows the csr, req_ and rsp_ channels of signed_integer_text_parser,
// predicts each parsed number from the accepted characters and compares it with rsp_ words
// depends on sitp_pkg for widths, character codes and the parse phase encoding
module text_parser_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sitp_pkg::RADIX_W-1:0]        csr_write_data,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [sitp_pkg::CHAR_W-1:0]         req_text_char,
   input  logic                                req_string_start,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [sitp_pkg::VALUE_W-1:0] rsp_parsed_value,
   input  logic                                rsp_range_error,
   input  logic [sitp_pkg::OUT_OFF_W-1:0]      rsp_end_offset,
   output int                                  mismatch_count,
   output int                                  pending_count,
   output int                                  checked_count,
   output int                                  saturated_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;
   localparam int RADIX_W      = sitp_pkg::RADIX_W;
   localparam int CHAR_W       = sitp_pkg::CHAR_W;
   localparam int VALUE_W      = sitp_pkg::VALUE_W;
   localparam int OUT_OFF_W    = sitp_pkg::OUT_OFF_W;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      range_error;
      logic [OUT_OFF_W-1:0]      offset;
   } parse_result_type;

   parse_result_type expected_numbers[$];

   sitp_pkg::phase_type    phase;
   logic [RADIX_W-1:0]     radix_reg;
   logic [RADIX_W-1:0]     radix_now;
   logic [RADIX_W-1:0]     cut_dig;
   logic [VALUE_W-1:0]     acc;
   logic [VALUE_W-1:0]     cut_val;
   logic [OUT_OFF_W-1:0]   char_pos;
   logic                   neg;
   logic                   saturated;
   logic                   got_digits;
   int                     errors;
   int                     checked;
   int                     saturations;

   task automatic end_number();
      parse_result_type r;
      r.value = saturated ? (neg ? sitp_pkg::VALUE_MIN : sitp_pkg::VALUE_MAX)
                          : (neg ? -acc : acc);
      r.range_error = saturated;
      r.offset = got_digits ? char_pos : '0;
      expected_numbers.push_back(r);
      phase = sitp_pkg::PH_IDLE;
   endtask

   // overflow threshold depends on the sign, so this runs once the sign is known
   task automatic pick_radix(input logic [RADIX_W-1:0] r);
      logic [VALUE_W-1:0] limit;
      logic [RADIX_W-1:0] base;
      limit = neg ? sitp_pkg::VALUE_MIN : sitp_pkg::VALUE_MAX;
      base = (r == sitp_pkg::RADIX_AUTO) ? sitp_pkg::RADIX_DEC : r;
      radix_now = base;
      cut_dig = RADIX_W'(limit % base);
      cut_val = limit / base;
   endtask

   task automatic take_digit(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] dv;
      if (ch >= sitp_pkg::CH_ZERO && ch <= sitp_pkg::CH_NINE)
         dv = ch - sitp_pkg::CH_ZERO;
      else if (ch >= sitp_pkg::CH_UPPER_A && ch <= sitp_pkg::CH_UPPER_Z)
         dv = ch - sitp_pkg::UPPER_BIAS;
      else if (ch >= sitp_pkg::CH_LOWER_A && ch <= sitp_pkg::CH_LOWER_Z)
         dv = ch - sitp_pkg::LOWER_BIAS;
      else
         dv = '1;
      if (dv >= radix_now) begin
         end_number();
      end else begin
         if (saturated || acc > cut_val || (acc == cut_val && dv > cut_dig))
            saturated = 1'b1;
         else
            acc = acc * radix_now + dv;
         got_digits = 1'b1;
      end
   endtask

   task automatic open_number(input logic [CHAR_W-1:0] ch);
      if ((radix_now == sitp_pkg::RADIX_AUTO || radix_now == sitp_pkg::RADIX_HEX) &&
          ch == sitp_pkg::CH_ZERO) begin
         phase = sitp_pkg::PH_ZERO;
      end else begin
         pick_radix(radix_now);
         phase = sitp_pkg::PH_DIGITS;
         take_digit(ch);
      end
   endtask

   task automatic parse_char(input logic [CHAR_W-1:0] ch, input logic first);
      logic skip;
      skip = 1'b0;
      if (first) begin
         phase = sitp_pkg::PH_SPACE;
         neg = 1'b0;
         acc = '0;
         saturated = 1'b0;
         got_digits = 1'b0;
         radix_now = radix_reg;
         cut_val = '0;
         cut_dig = '0;
         char_pos = '0;
      end else if (phase == sitp_pkg::PH_IDLE) begin
         skip = 1'b1;
      end else if (char_pos != '1) begin
         char_pos = char_pos + 1'b1;
      end
      if (!skip) begin
         case (phase)
            sitp_pkg::PH_SPACE: begin
               if (ch == sitp_pkg::CH_MINUS) begin
                  neg = 1'b1;
                  phase = sitp_pkg::PH_SIGNED;
               end else if (ch == sitp_pkg::CH_PLUS) begin
                  phase = sitp_pkg::PH_SIGNED;
               end else if (ch != sitp_pkg::CH_SPACE &&
                            !(ch >= sitp_pkg::CH_TAB && ch <= sitp_pkg::CH_CR)) begin
                  open_number(ch);
               end
            end
            sitp_pkg::PH_SIGNED: open_number(ch);
            sitp_pkg::PH_ZERO: begin
               if (ch == sitp_pkg::CH_LOWER_X || ch == sitp_pkg::CH_UPPER_X) begin
                  pick_radix(sitp_pkg::RADIX_HEX);
                  phase = sitp_pkg::PH_DIGITS;
               end else begin
                  // the leading zero counts as a digit once no prefix follows
                  pick_radix(radix_now == sitp_pkg::RADIX_AUTO ? sitp_pkg::RADIX_OCT
                                                               : sitp_pkg::RADIX_HEX);
                  acc = '0;
                  got_digits = 1'b1;
                  phase = sitp_pkg::PH_DIGITS;
                  take_digit(ch);
               end
            end
            sitp_pkg::PH_DIGITS: take_digit(ch);
            default: phase = sitp_pkg::PH_IDLE;
         endcase
      end
   endtask

   always @(posedge clock) begin
      parse_result_type want;
      if (reset) begin
         expected_numbers.delete();
         radix_reg = sitp_pkg::RADIX_RESET;
         phase = sitp_pkg::PH_IDLE;
         neg = 1'b0;
         acc = '0;
         saturated = 1'b0;
         got_digits = 1'b0;
         radix_now = '0;
         cut_val = '0;
         cut_dig = '0;
         char_pos = '0;
         errors = 0;
         checked = 0;
         saturations = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_numbers.size() == 0) begin
               if (errors < REPORT_LIMIT)
                  $display("%t: unexpected rsp word: value %0d range_error %0b offset %0d",
                           $realtime, rsp_parsed_value, rsp_range_error, rsp_end_offset);
               errors++;
            end else begin
               want = expected_numbers.pop_front();
               checked++;
               if (want.range_error)
                  saturations++;
               if (rsp_parsed_value !== want.value || rsp_range_error !== want.range_error ||
                   rsp_end_offset !== want.offset) begin
                  if (errors < REPORT_LIMIT)
                     $display("%t: rsp mismatch: exp %0d %0b %0d, got %0d %0b %0d",
                              $realtime, want.value, want.range_error, want.offset,
                              rsp_parsed_value, rsp_range_error, rsp_end_offset);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            parse_char(req_text_char, req_string_start);
         // radix is latched at string start, so a write never affects the word above
         if (csr_write_enable)
            radix_reg = csr_write_data;
      end
      mismatch_count <= errors;
      pending_count <= expected_numbers.size();
      checked_count <= checked;
      saturated_count <= saturations;
   end

endmodule

/* dv/signed_integer_text_parser_test.sv */
// signed_integer_text_parser_test: character stimulus, radix writes and verdict for the parser
// drives req_ strings under three idling profiles; text_parser_checker checks every rsp_ word
// depends on sitp_pkg, signed_integer_text_parser and text_parser_checker
module signed_integer_text_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RADIX_W        = sitp_pkg::RADIX_W;
   localparam int CHAR_W         = sitp_pkg::CHAR_W;
   localparam int VALUE_W        = sitp_pkg::VALUE_W;
   localparam int OUT_OFF_W      = sitp_pkg::OUT_OFF_W;
   localparam int CLOCK_PERIOD   = 20;
   localparam int SETTLE_CYCLES  = 6;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 270;
   localparam int SEGMENT_ITEMS  = 30;
   localparam int LONG_RUN       = 60;
   localparam int POOL_SIZE      = 10;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [RADIX_W-1:0]         csr_write_data = sitp_pkg::RADIX_RESET;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CHAR_W-1:0]          req_text_char = '0;
   logic                       req_string_start = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0]  rsp_parsed_value;
   logic                       rsp_range_error;
   logic [OUT_OFF_W-1:0]       rsp_end_offset;
   int                         mismatch_count;
   int                         pending_count;
   int                         checked_count;
   int                         saturated_count;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_requests = 0;
   int stalls_taken = 0;
   int quiet_cycles = 0;
   int chars_sent = 0;
   int radix_writes = 0;
   logic [RADIX_W-1:0] current_radix = sitp_pkg::RADIX_RESET;
   logic [RADIX_W-1:0] radix_pool [POOL_SIZE] = '{sitp_pkg::RADIX_AUTO, sitp_pkg::RADIX_DEC,
                                                  sitp_pkg::RADIX_HEX, sitp_pkg::RADIX_OCT,
                                                  6'd2, 6'd36, 6'd1, 6'd63, 6'd3, 6'd37};

   signed_integer_text_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_char    (req_text_char),
      .req_string_start (req_string_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_range_error  (rsp_range_error),
      .rsp_end_offset   (rsp_end_offset)
   );

   text_parser_checker checker_inst (.*);

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // receiver: random ready, or a long hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (stalls_taken != stall_requests) begin
            stalls_taken++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_char(input logic [CHAR_W-1:0] ch, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_char <= ch;
      req_string_start <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_W-1:0] r);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= r;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      current_radix = r;
      radix_writes++;
   endtask

   function automatic logic [CHAR_W-1:0] digit_char(input int unsigned v);
      if (v < 10)
         return sitp_pkg::CH_ZERO + CHAR_W'(v);
      return (($urandom_range(1) == 0) ? sitp_pkg::CH_UPPER_A : sitp_pkg::CH_LOWER_A) +
             CHAR_W'(v - 10);
   endfunction

   // optional whitespace, sign and prefix, digits in the active radix and mostly a terminator
   task automatic send_number();
      logic [CHAR_W-1:0]  text[$];
      logic [CHAR_W-1:0]  digits[$];
      logic [CHAR_W-1:0]  term;
      logic [CHAR_W-1:0]  tv;
      logic [VALUE_W-1:0] mag;
      logic [RADIX_W-1:0] base;
      int unsigned        mode;
      int unsigned        sel;
      int unsigned        n_dig;
      int unsigned        top_digit;
      repeat (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0) begin
         sel = $urandom_range(5);
         text.push_back((sel == 5) ? sitp_pkg::CH_SPACE : sitp_pkg::CH_TAB + CHAR_W'(sel));
      end
      case ($urandom_range(3))
         0: text.push_back(sitp_pkg::CH_MINUS);
         1: text.push_back(sitp_pkg::CH_PLUS);
         default: ;
      endcase
      base = current_radix;
      if (current_radix == sitp_pkg::RADIX_AUTO) begin
         sel = $urandom_range(2);
         base = (sel == 0) ? sitp_pkg::RADIX_DEC :
                (sel == 1) ? sitp_pkg::RADIX_OCT : sitp_pkg::RADIX_HEX;
         if (sel != 0)
            text.push_back(sitp_pkg::CH_ZERO);
         if (sel == 2)
            text.push_back(($urandom_range(1) == 0) ? sitp_pkg::CH_LOWER_X
                                                     : sitp_pkg::CH_UPPER_X);
      end else if (current_radix == sitp_pkg::RADIX_HEX && $urandom_range(1) == 1) begin
         text.push_back(sitp_pkg::CH_ZERO);
         text.push_back(($urandom_range(1) == 0) ? sitp_pkg::CH_LOWER_X
                                                  : sitp_pkg::CH_UPPER_X);
      end
      mode = $urandom_range(9);
      if (base >= 2 && base <= 36 && mode < 3) begin
         // values around the signed limits, or any 64-bit pattern
         mag = (mode == 0) ? {$urandom, $urandom}
                           : sitp_pkg::VALUE_MAX - 64'd1 + 64'($urandom_range(3));
         do begin
            digits.push_front(digit_char(int'(mag % base)));
            mag = mag / base;
         end while (mag != 0);
      end else begin
         top_digit = (base > 36) ? 35 : base - 1;
         n_dig = (mode == 3) ? $urandom_range(10, 70) : $urandom_range(6);
         repeat (n_dig) digits.push_back(digit_char($urandom_range(top_digit)));
      end
      text = {text, digits};
      term = ($urandom_range(3) == 0) ? 8'h00 : CHAR_W'($urandom_range(255));
      if (term >= sitp_pkg::CH_ZERO && term <= sitp_pkg::CH_NINE)
         tv = term - sitp_pkg::CH_ZERO;
      else if (term >= sitp_pkg::CH_UPPER_A && term <= sitp_pkg::CH_UPPER_Z)
         tv = term - sitp_pkg::UPPER_BIAS;
      else if (term >= sitp_pkg::CH_LOWER_A && term <= sitp_pkg::CH_LOWER_Z)
         tv = term - sitp_pkg::LOWER_BIAS;
      else
         tv = '1;
      if (tv < base)
         term = 8'h00;
      // now and then the string is left open and the next start abandons it
      if ($urandom_range(9) != 0)
         text.push_back(term);
      foreach (text[i]) push_char(text[i], i == 0);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6))
         push_char(CHAR_W'($urandom_range(255)), $urandom_range(2) == 0);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   task automatic run_random(input logic with_hold_off);
      int first_char;
      int seg_start;
      int seg;
      first_char = chars_sent;
      seg = 0;
      if (with_hold_off)
         stall_requests <= stall_requests + 1;
      while (chars_sent - first_char < PHASE_ITEMS) begin
         write_radix((seg < POOL_SIZE) ? radix_pool[seg] : RADIX_W'($urandom_range(63)));
         seg_start = chars_sent;
         while (chars_sent - seg_start < SEGMENT_ITEMS) begin
            if ($urandom_range(4) == 0)
               send_noise();
            else
               send_number();
         end
         seg++;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_idling(26, 69);

      // stray word while idle, then whitespace, sign, a digit and a 0xff terminator
      push_char("z", 1'b0);
      push_char(" ", 1'b1);
      push_char("-", 1'b0);
      push_char("9", 1'b0);
      push_char(8'hFF, 1'b0);
      // restart in the middle of a number, ended by a nul
      push_char("1", 1'b1);
      push_char("2", 1'b1);
      push_char(8'h00, 1'b0);
      write_radix(sitp_pkg::RADIX_AUTO);
      push_char("0", 1'b1);
      push_char("x", 1'b0);
      push_char("g", 1'b0);
      push_char("0", 1'b1);
      push_char("7", 1'b0);
      push_char("8", 1'b0);
      push_char("-", 1'b1);
      push_char(8'h00, 1'b0);
      write_radix(6'd36);
      push_char("z", 1'b1);
      push_char("Z", 1'b0);
      push_char("!", 1'b0);
      write_radix(6'd1);
      push_char("0", 1'b1);
      push_char("1", 1'b0);
      write_radix(6'd63);
      push_char("z", 1'b1);
      push_char("{", 1'b0);

      run_random(1'b1);
      set_idling(69, 26);
      run_random(1'b1);
      set_idling(0, 0);
      run_random(1'b0);

      // a long run of leading zeros before the last digit
      write_radix(sitp_pkg::RADIX_DEC);
      push_char("0", 1'b1);
      repeat (LONG_RUN) push_char("0", 1'b0);
      push_char("7", 1'b0);
      push_char(8'h00, 1'b0);

      wait_drained();
      $display("%0d characters sent over %0d radix writes, %0d numbers checked, %0d saturated",
               chars_sent, radix_writes, checked_count, saturated_count);
      $display("idling by sender, by receiver and none; receiver hold-offs: %0d", stalls_taken);
      if (mismatch_count == 0 && pending_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* files.f */
design/sitp_pkg.sv
design/sitp_ctrl.sv
design/sitp_datapath.sv
design/signed_integer_text_parser.sv
dv/text_parser_checker.sv
dv/signed_integer_text_parser_test.sv
